// ===== hw/rtl/lru_set_assoc_cache_tags_assert.svh =====
// Assertion macros shared by the cache tag store RTL.
`ifndef LRU_SET_ASSOC_CACHE_TAGS_ASSERT_SVH
`define LRU_SET_ASSOC_CACHE_TAGS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LSCT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LSCT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lsct_pkg.sv =====
// Shared types and codes for the LRU set-associative cache tag store.
`timescale 1ns / 1ps

package lsct_pkg;

	localparam int ADDR_W    = 64;
	localparam int TAG_W     = 64;
	localparam int STAMP_W   = 32;
	localparam int CNT_W     = 32;
	localparam int SETNUM_W  = 6;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	// Command codes
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;
	localparam logic [1:0] CMD_IFETCH = 2'd3;

	// Outcome codes
	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_MISS  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;
	localparam logic [1:0] OUT_NONE  = 2'd3;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_INDEX_BITS  = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

	localparam logic [2:0] INDEX_BITS_RST  = 3'd4;
	localparam logic [5:0] OFFSET_BITS_RST = 6'd4;
	localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] address;
	} access_t;

	typedef struct packed {
		logic [1:0]          first_outcome;
		logic [1:0]          second_outcome;
		logic [SETNUM_W-1:0] set_number;
		logic [CNT_W-1:0]    hit_total;
		logic [CNT_W-1:0]    miss_total;
		logic [CNT_W-1:0]    eviction_total;
	} result_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

endpackage

// ===== hw/rtl/lsct_if.sv =====
// Valid/ready channel interface carrying one item of a given type.
`timescale 1ns / 1ps

interface lsct_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lsct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lsct_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 512
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/lru_set_assoc_cache_tags.sv =====
// LRU set-associative cache tag store: top level with way-scanning sequencer.
//
// Usage: items arrive on the access channel (cmd, address) under valid/ready and
// results leave on the result channel. Load, store and modify each give one
// result; an instruction fetch is taken and dropped with no result. Three
// registers on the APB port (index_bits, offset_bits, ways_in_use) are to be
// written only while idle, which the block does not enforce; pready is tied high.
// Sequence: accept, split the address and bump the stamp clock, stream the W used
// ways of the set through the line RAM read port and the single compare unit,
// write the chosen line back, then load the output register. The next item is
// taken only once the result is loaded and the sequencer is idle again.
// The line RAM read port, one way per cycle, limits the scan.
// A modify's second access always hits the line the first one just touched, so
// it only adds to the hit count and costs no extra scan.
// Reset: counters, stamp clock and registers clear to their reset values, then a
// clearing pass writes every line empty, one line per cycle (512 lines at the
// default sizes); access.ready stays low meanwhile, APB writes are taken.
// Stall: a finished result holds in the output register until taken; the next
// item may be accepted meanwhile and waits in its final step if still stalled.
`timescale 1ns / 1ps
`include "lru_set_assoc_cache_tags_assert.svh"

module lru_set_assoc_cache_tags
	import lsct_pkg::*;
#(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	lsct_if.sink               access,
	lsct_if.source             result
);

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int LINES    = NUM_SETS * MAX_WAYS;
	localparam int LINE_AW  = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
	localparam int IB_W     = 4;
	localparam int SHIFT_W  = 7;
	localparam int LINE_W   = $bits(line_t);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SPLIT = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	// Configuration
	logic [2:0] cfg_ib_q;
	logic [5:0] cfg_ob_q;
	logic [3:0] cfg_ways_q;

	// Sequencer and counters
	logic [2:0]         state_q;
	logic [LINE_AW-1:0] clr_addr_q;
	logic [STAMP_W-1:0] stamp_clk_q;
	logic [CNT_W-1:0]   hit_cnt_q;
	logic [CNT_W-1:0]   miss_cnt_q;
	logic [CNT_W-1:0]   evict_cnt_q;

	// Item being worked on
	logic [1:0]        cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SET_W-1:0]  set_q;
	logic [TAG_W-1:0]  tag_q;

	// Scan state
	logic [WCNT_W-1:0]  iw_q;
	logic               rd_vld_q;
	logic [WAY_W-1:0]   rd_way_q;
	logic               hit_q;
	logic [WAY_W-1:0]   hit_way_q;
	logic               empty_q;
	logic [WAY_W-1:0]   empty_way_q;
	logic [STAMP_W-1:0] min_stamp_q;
	logic [WAY_W-1:0]   victim_q;
	logic [1:0]         first_q;

	// Output register
	logic    rsp_vld_q;
	result_t rsp_data_q;

	// Combinational
	logic [WCNT_W-1:0]  used_ways;
	logic [IB_W-1:0]    used_ib;
	logic [ADDR_W-1:0]  shifted;
	logic [SET_W-1:0]   set_mask;
	logic [SET_W-1:0]   set_new;
	logic [SHIFT_W-1:0] shift_tag;
	logic [TAG_W-1:0]   tag_new;
	logic [STAMP_W-1:0] stamp_next;
	logic               issue;
	logic               last_way;
	logic               rsp_load;
	logic [WAY_W-1:0]   wr_way;
	logic [1:0]         outcome;
	logic [1:0]         hit_inc;
	line_t              rd_line;
	line_t              wr_line;

	logic               ram_we;
	logic [LINE_AW-1:0] ram_waddr;
	logic [LINE_W-1:0]  ram_wdata;
	logic [LINE_AW-1:0] ram_raddr;
	logic [LINE_W-1:0]  ram_rdata;

	// Clamp the way count to 1..MAX_WAYS and the index width to MAX_SET_BITS
	always_comb begin
		if (cfg_ways_q == '0) begin
			used_ways = WCNT_W'(1);
		end else if (32'(cfg_ways_q) > MAX_WAYS) begin
			used_ways = WCNT_W'(MAX_WAYS);
		end else begin
			used_ways = WCNT_W'(cfg_ways_q);
		end
		if (32'(cfg_ib_q) > MAX_SET_BITS) begin
			used_ib = IB_W'(MAX_SET_BITS);
		end else begin
			used_ib = IB_W'(cfg_ib_q);
		end
	end

	// Address split: set from the bits above the offset, tag above the set.
	// A tag shift of 64 or more leaves zero.
	always_comb begin
		shifted = addr_q >> cfg_ob_q;
		for (int i = 0; i < SET_W; i++) begin
			set_mask[i] = (i < int'(used_ib));
		end
		set_new   = shifted[SET_W-1:0] & set_mask;
		shift_tag = SHIFT_W'(cfg_ob_q) + SHIFT_W'(used_ib);
		tag_new   = addr_q >> shift_tag;
	end

	// Stamp clock skips zero so a line is never stamped empty
	assign stamp_next = (stamp_clk_q == '1) ? STAMP_W'(1) : stamp_clk_q + STAMP_W'(1);

	assign issue    = (state_q == ST_SCAN) && (iw_q < used_ways);
	assign last_way = rd_vld_q && (WCNT_W'(32'(rd_way_q) + 1) == used_ways);
	assign rd_line  = line_t'(ram_rdata);

	// Load the output register once the emit step finds it free
	assign rsp_load = (state_q == ST_EMIT) && (!rsp_vld_q || result.ready);

	// Choose the line to write back and the outcome of the first access
	always_comb begin
		if (hit_q) begin
			wr_way  = hit_way_q;
			outcome = OUT_HIT;
		end else if (empty_q) begin
			wr_way  = empty_way_q;
			outcome = OUT_MISS;
		end else begin
			wr_way  = victim_q;
			outcome = OUT_EVICT;
		end
		hit_inc = {1'b0, hit_q} + {1'b0, cmd_q == CMD_MODIFY};
		wr_line.tag   = tag_q;
		wr_line.stamp = stamp_clk_q;
	end

	// Line RAM: clearing pass writes zeros, write-back writes the chosen way
	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q
		: LINE_AW'(32'(set_q) * MAX_WAYS + 32'(wr_way));
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : LINE_W'(wr_line);
	assign ram_raddr = LINE_AW'(32'(set_q) * MAX_WAYS + 32'(WAY_W'(iw_q)));

	lsct_ram #(
		.WIDTH(LINE_W),
		.DEPTH(LINES)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// APB configuration port
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_INDEX_BITS:  prdata = PDATA_W'(cfg_ib_q);
			REG_OFFSET_BITS: prdata = PDATA_W'(cfg_ob_q);
			REG_WAYS_IN_USE: prdata = PDATA_W'(cfg_ways_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ib_q   <= INDEX_BITS_RST;
			cfg_ob_q   <= OFFSET_BITS_RST;
			cfg_ways_q <= WAYS_IN_USE_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_INDEX_BITS:  cfg_ib_q   <= pwdata[2:0];
				REG_OFFSET_BITS: cfg_ob_q   <= pwdata[5:0];
				REG_WAYS_IN_USE: cfg_ways_q <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// Channels
	assign access.ready = (state_q == ST_IDLE);
	assign result.valid = rsp_vld_q;
	assign result.data  = rsp_data_q;

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			stamp_clk_q <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			iw_q        <= '0;
			rd_vld_q    <= 1'b0;
			rsp_vld_q   <= 1'b0;
		end else begin
			// raise on a fresh result, drop once the receiver takes it
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (result.ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + LINE_AW'(1);
					if (clr_addr_q == LINE_AW'(LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					// drop instruction fetches on the spot
					if (access.valid && access.data.cmd != CMD_IFETCH) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					stamp_clk_q <= stamp_next;
					iw_q        <= '0;
					rd_vld_q    <= 1'b0;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue) begin
						iw_q <= iw_q + WCNT_W'(1);
					end
					rd_vld_q <= issue;
					if (last_way) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					hit_cnt_q <= hit_cnt_q + CNT_W'(hit_inc);
					if (!hit_q) begin
						miss_cnt_q <= miss_cnt_q + CNT_W'(1);
					end
					if (!hit_q && !empty_q) begin
						evict_cnt_q <= evict_cnt_q + CNT_W'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload and scan bookkeeping
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q  <= access.data.cmd;
				addr_q <= access.data.address;
			end
			ST_SPLIT: begin
				set_q   <= set_new;
				tag_q   <= tag_new;
				hit_q   <= 1'b0;
				empty_q <= 1'b0;
			end
			ST_SCAN: begin
				rd_way_q <= WAY_W'(iw_q);
				if (rd_vld_q) begin
					// last empty way wins; first matching tag wins
					if (rd_line.stamp == '0) begin
						empty_q     <= 1'b1;
						empty_way_q <= rd_way_q;
					end else if (rd_line.tag == tag_q && !hit_q) begin
						hit_q     <= 1'b1;
						hit_way_q <= rd_way_q;
					end
					// strictly older replaces, so the lowest way keeps a tie
					if (rd_way_q == '0 || rd_line.stamp < min_stamp_q) begin
						min_stamp_q <= rd_line.stamp;
						victim_q    <= rd_way_q;
					end
				end
			end
			ST_WRITE: begin
				first_q <= outcome;
			end
			ST_EMIT: begin
				if (!rsp_vld_q || result.ready) begin
					rsp_data_q.first_outcome  <= first_q;
					rsp_data_q.second_outcome <= (cmd_q == CMD_MODIFY) ? OUT_HIT : OUT_NONE;
					rsp_data_q.set_number     <= SETNUM_W'(set_q);
					rsp_data_q.hit_total      <= hit_cnt_q;
					rsp_data_q.miss_total     <= miss_cnt_q;
					rsp_data_q.eviction_total <= evict_cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	`LSCT_ASSERT_IMP(a_clear_blocks_items, state_q == ST_CLEAR,
		!access.ready && ram_we, "item accepted or RAM idle during clearing pass")
	`LSCT_ASSERT_IMP(a_stamp_nonzero, state_q == ST_WRITE,
		stamp_clk_q != '0, "line written back with the empty stamp")
	`LSCT_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN,
		iw_q <= used_ways, "scan ran past the used ways")
	`LSCT_ASSERT_NXT(a_rsp_from_emit, !rsp_vld_q && state_q != ST_EMIT,
		!rsp_vld_q, "result raised outside the emit step")

endmodule

// ===== tb/lru_set_assoc_cache_tags_tb.sv =====
// Self-checking testbench for the LRU set-associative cache tag store.
`timescale 1ns / 1ps

module lru_set_assoc_cache_tags_tb;
	import lsct_pkg::*;

	localparam int SET_BITS_MAX = 6;
	localparam int WAYS_MAX     = 8;
	localparam int LINE_COUNT   = (1 << SET_BITS_MAX) * WAYS_MAX;
	// The longest item scans up to 8 ways; a dropped instruction fetch
	// gives no result, so settle this long before touching the registers.
	localparam int SETTLE_CYCLES = 24;
	localparam int RUN_LIMIT_NS  = 2_000_000;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	lsct_if #(.item_t(access_t)) access_ch ();
	lsct_if #(.item_t(result_t)) result_ch ();

	lru_set_assoc_cache_tags dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.access  (access_ch.sink),
		.result  (result_ch.source)
	);

	// Shadow copy of the tag store: tags, last-use stamps, stamp clock, totals.
	logic [TAG_W-1:0]   tag_mem   [LINE_COUNT];
	logic [STAMP_W-1:0] stamp_mem [LINE_COUNT];
	logic [STAMP_W-1:0] use_clock;
	logic [CNT_W-1:0]   hit_count;
	logic [CNT_W-1:0]   miss_count;
	logic [CNT_W-1:0]   evict_count;

	// Shadow copy of the register file.
	logic [2:0] cfg_index_bits;
	logic [5:0] cfg_offset_bits;
	logic [3:0] cfg_ways;

	result_t     pending_results [$];
	int unsigned mismatch_count;
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;

	// 4 ns clock, low half first.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Drive every input to a known value from time zero.
	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		access_ch.valid    = 1'b0;
		access_ch.data     = '0;
		result_ch.ready    = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		mismatch_count     = 0;
	end

	// Receiver side: stall at random, re-decided on every falling edge.
	always @(negedge clk) begin
		result_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic int unsigned live_index_bits();
		return (cfg_index_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_index_bits;
	endfunction

	function automatic int unsigned live_ways();
		if (cfg_ways == 0)
			return 1;
		return (cfg_ways > WAYS_MAX) ? WAYS_MAX : cfg_ways;
	endfunction

	// One lookup in a set: refresh on a hit, otherwise fill the last empty way,
	// otherwise replace the oldest stamp (lowest way wins a tie).
	function automatic logic [1:0] lookup_set(int unsigned set_idx, logic [TAG_W-1:0] tag,
			logic [STAMP_W-1:0] stamp);
		int unsigned base;
		int unsigned ways;
		int unsigned empty_way;
		int unsigned victim;
		bit          have_empty;
		base       = (set_idx % (1 << SET_BITS_MAX)) * WAYS_MAX;
		ways       = live_ways();
		have_empty = 1'b0;
		empty_way  = 0;
		for (int w = 0; w < ways; w++) begin
			if (stamp_mem[base + w] == '0) begin
				have_empty = 1'b1;
				empty_way  = w;
			end else if (tag_mem[base + w] == tag) begin
				stamp_mem[base + w] = stamp;
				hit_count++;
				return OUT_HIT;
			end
		end
		miss_count++;
		if (have_empty) begin
			tag_mem[base + empty_way]   = tag;
			stamp_mem[base + empty_way] = stamp;
			return OUT_MISS;
		end
		evict_count++;
		victim = 0;
		for (int w = 1; w < ways; w++)
			if (stamp_mem[base + w] < stamp_mem[base + victim])
				victim = w;
		tag_mem[base + victim]   = tag;
		stamp_mem[base + victim] = stamp;
		return OUT_EVICT;
	endfunction

	// Work out the result of one accepted item; returns 0 when none is due.
	function automatic bit predict_lookup(input access_t item, output result_t res);
		int unsigned      ib;
		int unsigned      ob;
		int unsigned      set_idx;
		logic [TAG_W-1:0] tag;
		res = '0;
		if (item.cmd == CMD_IFETCH)
			return 1'b0;
		ib      = live_index_bits();
		ob      = cfg_offset_bits;
		set_idx = (ob >= ADDR_W) ? 0 : int'((item.address >> ob) & ((64'd1 << ib) - 64'd1));
		tag     = (ib + ob >= ADDR_W) ? '0 : (item.address >> (ib + ob));
		use_clock++;
		// Skip zero on wrap so a live line is never stamped empty.
		if (use_clock == '0)
			use_clock = 1;
		res.first_outcome  = lookup_set(set_idx, tag, use_clock);
		res.second_outcome = (item.cmd == CMD_MODIFY) ? lookup_set(set_idx, tag, use_clock)
			: OUT_NONE;
		res.set_number     = set_idx[SETNUM_W-1:0];
		res.hit_total      = hit_count;
		res.miss_total     = miss_count;
		res.eviction_total = evict_count;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic report_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name,
				exp_val, act_val);
		end
	endtask

	// Compare each taken result with the oldest outstanding lookup.
	always @(posedge clk) begin : check_results
		result_t exp_res;
		result_t act_res;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			act_res = result_ch.data;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none actual 0x%0h", $time,
					act_res);
			end else begin
				exp_res = pending_results.pop_front();
				report_field("first_outcome", exp_res.first_outcome, act_res.first_outcome);
				report_field("second_outcome", exp_res.second_outcome,
					act_res.second_outcome);
				report_field("set_number", exp_res.set_number, act_res.set_number);
				report_field("hit_total", exp_res.hit_total, act_res.hit_total);
				report_field("miss_total", exp_res.miss_total, act_res.miss_total);
				report_field("eviction_total", exp_res.eviction_total,
					act_res.eviction_total);
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one item, hold it until taken, then predict. Call on a falling edge.
	task automatic send_access(input logic [1:0] cmd, input logic [ADDR_W-1:0] address);
		access_t item;
		result_t exp_res;
		item.cmd     = cmd;
		item.address = address;
		while ($urandom_range(99) < sender_idle_pct) begin
			access_ch.valid = 1'b0;
			@(negedge clk);
		end
		access_ch.data  = item;
		access_ch.valid = 1'b1;
		@(posedge clk);
		while (!access_ch.ready)
			@(posedge clk);
		if (predict_lookup(item, exp_res))
			pending_results.push_back(exp_res);
		@(negedge clk);
		access_ch.valid = 1'b0;
	endtask

	// Two-phase register write; the shadow copy changes at the access edge.
	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_INDEX_BITS:  cfg_index_bits  = value[2:0];
			REG_OFFSET_BITS: cfg_offset_bits = value[5:0];
			REG_WAYS_IN_USE: cfg_ways        = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Two-phase register read, checked against the shadow value.
	task automatic check_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] exp_val);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b0;
		penable = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		report_field("register readback", exp_val, prdata);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Drain outstanding lookups, let a dropped fetch settle, then hold the block idle.
	task automatic wait_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Reprogram all three registers while idle and read them back.
	task automatic apply_config(input logic [2:0] ib, input logic [5:0] ob,
			input logic [3:0] ways);
		wait_idle();
		write_reg(REG_INDEX_BITS, {29'd0, ib});
		write_reg(REG_OFFSET_BITS, {26'd0, ob});
		write_reg(REG_WAYS_IN_USE, {28'd0, ways});
		check_reg(REG_INDEX_BITS, {29'd0, cfg_index_bits});
		check_reg(REG_OFFSET_BITS, {26'd0, cfg_offset_bits});
		check_reg(REG_WAYS_IN_USE, {28'd0, cfg_ways});
	endtask

	// Address aimed at a few sets and a small tag pool so that hits and
	// evictions are common; one in ten is fully random.
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned       ib;
		int unsigned       ob;
		logic [ADDR_W-1:0] set_mask;
		logic [ADDR_W-1:0] set_val;
		logic [ADDR_W-1:0] tag_val;
		logic [ADDR_W-1:0] low_bits;
		ib       = live_index_bits();
		ob       = cfg_offset_bits;
		set_mask = (64'd1 << ib) - 64'd1;
		low_bits = {$urandom, $urandom} & ((64'd1 << ob) - 64'd1);
		if ($urandom_range(9) == 0)
			return {$urandom, $urandom};
		set_val = ($urandom_range(99) < 70) ? (64'($urandom_range(3)) & set_mask)
			: (64'($urandom) & set_mask);
		tag_val = 64'($urandom_range(live_ways() + 2));
		if ($urandom_range(9) == 0)
			tag_val = {$urandom, $urandom};
		return low_bits | (set_val << ob) | ((ib + ob >= ADDR_W) ? '0 : (tag_val << (ib + ob)));
	endfunction

	function automatic logic [1:0] pick_cmd();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return CMD_IFETCH;
		if (r < 36)
			return CMD_LOAD;
		if (r < 64)
			return CMD_STORE;
		return CMD_MODIFY;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: 16 sets, 16-byte lines, direct mapped.
	task automatic test_reset_config();
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_STORE, 64'h10);
		send_access(CMD_MODIFY, 64'h100);
		send_access(CMD_IFETCH, 64'h0);
		send_access(CMD_LOAD, '1);
		send_access(CMD_LOAD, 64'h0);
		send_access(CMD_MODIFY, '1);
	endtask

	// Out-of-range register values: index width clamps to 6, way count to 1 or 8.
	task automatic test_clamped_config();
		apply_config(3'd7, 6'd0, 4'd15);
		send_access(CMD_LOAD, 64'h7F);
		send_access(CMD_STORE, 64'h3F);
		apply_config(3'd0, 6'd0, 4'd0);
		send_access(CMD_LOAD, 64'h5);
		send_access(CMD_LOAD, 64'h6);
	endtask

	// Offsets so wide that the tag or part of the set is shifted out.
	task automatic test_wide_offset();
		apply_config(3'd6, 6'd63, 4'd8);
		send_access(CMD_LOAD, '1);
		send_access(CMD_MODIFY, 64'h8000_0000_0000_0000);
		apply_config(3'd6, 6'd60, 4'd2);
		send_access(CMD_STORE, '1);
		send_access(CMD_LOAD, 64'h0FFF_FFFF_FFFF_FFFF);
	endtask

	// Fill one set, refresh one line, then force the oldest out.
	task automatic test_lru_order();
		apply_config(3'd0, 6'd0, 4'd4);
		for (int t = 1; t <= 4; t++)
			send_access(CMD_LOAD, 64'(t));
		send_access(CMD_LOAD, 64'd1);
		send_access(CMD_STORE, 64'd5);
		send_access(CMD_MODIFY, 64'd3);
	endtask

	// Shrink and regrow the way count: lines are kept, not flushed.
	task automatic test_way_resize();
		apply_config(3'd0, 6'd0, 4'd2);
		send_access(CMD_LOAD, 64'd1);
		send_access(CMD_LOAD, 64'd6);
		apply_config(3'd0, 6'd0, 4'd4);
		send_access(CMD_LOAD, 64'd5);
		send_access(CMD_LOAD, 64'd1);
	endtask

	// Random traffic under one setting and one idle pattern.
	task automatic run_random_phase(input logic [2:0] ib, input logic [5:0] ob,
			input logic [3:0] ways, input int unsigned idle_pct,
			input int unsigned stall_pct, input int unsigned lookups);
		int unsigned sent;
		logic [1:0]  cmd;
		apply_config(ib, ob, ways);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		sent               = 0;
		while (sent < lookups) begin
			cmd = pick_cmd();
			send_access(cmd, pick_address());
			if (cmd != CMD_IFETCH)
				sent++;
		end
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(3'd2, 6'd4, 4'd4, 0, 0, 130);
		run_random_phase(3'd0, 6'd0, 4'd8, 73, 0, 110);
		run_random_phase(3'd6, 6'd32, 4'd2, 0, 73, 110);
		run_random_phase(3'd7, 6'd63, 4'd15, 21, 21, 90);
		run_random_phase(3'd3, 6'd6, 4'd0, 0, 0, 110);
		run_random_phase(3'd1, 6'd60, 4'd3, 73, 0, 100);
		run_random_phase(3'd5, 6'd10, 4'd8, 21, 21, 110);
		run_random_phase(3'd4, 6'd4, 4'd1, 0, 73, 60);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		// Predictor starts from the reset state: every line empty.
		for (int i = 0; i < LINE_COUNT; i++) begin
			tag_mem[i]   = '0;
			stamp_mem[i] = '0;
		end
		use_clock       = '0;
		hit_count       = '0;
		miss_count      = '0;
		evict_count     = '0;
		cfg_index_bits  = INDEX_BITS_RST;
		cfg_offset_bits = OFFSET_BITS_RST;
		cfg_ways        = WAYS_IN_USE_RST;

		// Hold reset, then release it on a falling edge; the block
		// then runs its clearing pass with access.ready low.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_clamped_config();
		test_wide_offset();
		test_lru_order();
		test_way_resize();
		test_random_traffic();

		wait_idle();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
